FILE: src/vfc_pkg.sv
// ============================================================================
// vfc_pkg: shared types and constants for the voxel face culling block
// Operation codes, face direction codes, mark bit layout and field widths.
// ============================================================================
package vfc_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 7;
    localparam int FACE_W    = 6;
    localparam int IDX_W     = 18;
    localparam int CNT_W     = 19;
    localparam int DIR_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam int FACE_COUNT = 6;

    typedef enum logic [1:0] {
        OP_MARK     = 2'd0,
        OP_CLASSIFY = 2'd1,
        OP_EMIT     = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    // Face directions; the self code addresses the cell itself.
    localparam logic [DIR_W-1:0] DIR_PX   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NX   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NY   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_SELF = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Two mark bits per cell: occupied and visible
    typedef logic [1:0] t_marks;
    localparam int     MARK_OCC = 0;
    localparam int     MARK_VIS = 1;
    localparam t_marks MASK_OCC = 2'b01;
    localparam t_marks MASK_VIS = 2'b10;

    typedef struct packed {
        logic   wr_en;
        logic   rd_en;
        t_marks wr_data;
    } t_mem_ctl;

endpackage

FILE: src/vfc_cell_mem.sv
// ============================================================================
// vfc_cell_mem: single-port cell mark store
// One access per cycle, either a write or a read with registered read data.
// ============================================================================
module vfc_cell_mem #(
    parameter int ADDR_W = 18
) (
    input  logic                i_clk,
    input  vfc_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]   i_addr,
    output vfc_pkg::t_marks     o_rd_data
);
    import vfc_pkg::*;

    t_marks r_mem [2**ADDR_W];
    t_marks r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wr_data;
        end else if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/vfc_nbr_unit.sv
// ============================================================================
// vfc_nbr_unit: neighbour address and grid bounds unit
// Steps one axis of the base position by one and checks the result against
// the grid size, giving the cell address of the neighbour or of the cell.
// ============================================================================
module vfc_nbr_unit #(
    parameter int MAX_DIM = 64,
    parameter int DIM_W   = 6
) (
    input  logic [vfc_pkg::COORD_W-1:0] i_x,
    input  logic [vfc_pkg::COORD_W-1:0] i_y,
    input  logic [vfc_pkg::COORD_W-1:0] i_z,
    input  logic [vfc_pkg::DIR_W-1:0]   i_dir,
    input  logic [vfc_pkg::SIZE_W-1:0]  i_size_x,
    input  logic [vfc_pkg::SIZE_W-1:0]  i_size_y,
    input  logic [vfc_pkg::SIZE_W-1:0]  i_size_z,
    output logic                        o_in_grid,
    output logic [3*DIM_W-1:0]          o_addr
);
    import vfc_pkg::*;

    localparam int EXT_W = COORD_W + 1;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

    logic [EXT_W-1:0] sel;
    logic [EXT_W-1:0] moved;
    logic [EXT_W-1:0] nx, ny, nz;
    logic [EXT_W-1:0] eff_x, eff_y, eff_z;
    logic             on_x, on_y, on_z;

    always_comb begin
        on_x = (i_dir == DIR_PX) || (i_dir == DIR_NX);
        on_y = (i_dir == DIR_PY) || (i_dir == DIR_NY);
        on_z = (i_dir == DIR_PZ) || (i_dir == DIR_NZ);

        case (1'b1)
            on_y:    sel = {1'b0, i_y};
            on_z:    sel = {1'b0, i_z};
            default: sel = {1'b0, i_x};
        endcase

        // The step acts on the selected axis only: a step below zero wraps far above any size.
        case (i_dir)
            DIR_PX, DIR_PY, DIR_PZ: moved = sel + EXT_W'(1);
            DIR_NX, DIR_NY, DIR_NZ: moved = sel - EXT_W'(1);
            default:                moved = sel;
        endcase

        nx = on_x ? moved : {1'b0, i_x};
        ny = on_y ? moved : {1'b0, i_y};
        nz = on_z ? moved : {1'b0, i_z};

        eff_x = (EXT_W'(i_size_x) > MAX_EXT) ? MAX_EXT : EXT_W'(i_size_x);
        eff_y = (EXT_W'(i_size_y) > MAX_EXT) ? MAX_EXT : EXT_W'(i_size_y);
        eff_z = (EXT_W'(i_size_z) > MAX_EXT) ? MAX_EXT : EXT_W'(i_size_z);

        o_in_grid = (nx < eff_x) && (ny < eff_y) && (nz < eff_z);
        o_addr    = {nz[DIM_W-1:0], ny[DIM_W-1:0], nx[DIM_W-1:0]};
    end

endmodule

FILE: src/voxel_face_cull_top.sv
// Mark sets the cell's occupied bit; classify reads an occupied cell's six neighbours and
// sets its visible bit if a face is exposed; emit reads a visible cell's neighbours and
// hands out one result per exposed face. An out-of-grid position is dropped; clear sweeps
// the whole store. No new item is taken until the sequencer is idle again, as every step
// shares the one memory port. Reset (synchronous, active low) sets the sizes to 64, zeroes
// the counter and runs a clearing pass over the whole store before the first item.
// ============================================================================
// voxel_face_cull_top: hidden face culling over a voxel grid
// Keeps an occupied and a visible bit per cell and runs mark, classify,
// emit and clear transactions through a small sequencer that drives one
// single-port mark store and one shared neighbour address unit.
// ============================================================================
module voxel_face_cull_top #(
    parameter int MAX_DIM = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [vfc_pkg::COORD_W-1:0]    i_x_pos,
    input  logic [vfc_pkg::COORD_W-1:0]    i_y_pos,
    input  logic [vfc_pkg::COORD_W-1:0]    i_z_pos,
    // Result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vfc_pkg::IDX_W-1:0]      o_voxel_index,
    output logic [vfc_pkg::DIR_W-1:0]      o_face_dir,
    output logic [vfc_pkg::FACE_W-1:0]     o_face_x,
    output logic [vfc_pkg::FACE_W-1:0]     o_face_y,
    output logic [vfc_pkg::FACE_W-1:0]     o_face_z,
    output logic                           o_last_face,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfc_pkg::SIZE_W-1:0]     i_cfg_data
);
    import vfc_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 3 * DIM_W;

    // S_SELF checks the position and reads the cell itself, S_OWN acts on
    // its marks, S_NBR streams the six neighbour reads (one issued and one
    // judged per cycle), S_EMIT hands the exposed faces to the output
    // register and S_CLEAR sweeps the store.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF,
        S_OWN,
        S_NBR,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [COORD_W-1:0]      r_x, n_x, r_y, n_y, r_z, n_z;
    logic [DIR_W-1:0]        r_dir, n_dir;
    logic                    r_pv, n_pv;
    logic                    r_pin, n_pin;
    logic [DIR_W-1:0]        r_pdir, n_pdir;
    logic [FACE_COUNT-1:0]   r_exposed, n_exposed;
    logic [ADDR_W-1:0]       r_own_addr, n_own_addr;
    t_marks                  r_own_marks, n_own_marks;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_vis_count, n_vis_count;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic [SIZE_W-1:0]       r_size_x, r_size_y, r_size_z;
    logic                    r_out_valid, n_out_valid;
    logic [IDX_W-1:0]        r_out_idx, n_out_idx;
    logic [DIR_W-1:0]        r_out_dir, n_out_dir;
    logic [FACE_W-1:0]       r_out_x, n_out_x, r_out_y, n_out_y, r_out_z, n_out_z;
    logic                    r_out_last, n_out_last;

    t_mem_ctl                mem_ctl;
    logic [ADDR_W-1:0]       mem_addr;
    t_marks                  mem_rd_data;
    logic                    nbr_in_grid;
    logic [ADDR_W-1:0]       nbr_addr;
    logic                    in_accept;
    logic                    mark_bit;
    logic                    hit;
    logic [DIR_W-1:0]        sel_dir;
    logic [FACE_COUNT-1:0]   rest;

    // ------------------------------------------------------------------
    // Shared neighbour unit and mark store
    // ------------------------------------------------------------------
    vfc_nbr_unit #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_nbr (
        .i_x       (r_x),
        .i_y       (r_y),
        .i_z       (r_z),
        .i_dir     (r_dir),
        .i_size_x  (r_size_x),
        .i_size_y  (r_size_y),
        .i_size_z  (r_size_z),
        .o_in_grid (nbr_in_grid),
        .o_addr    (nbr_addr)
    );

    vfc_cell_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .o_rd_data (mem_rd_data)
    );

    // Items are taken only when the sequencer is idle; configuration is
    // always taken.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_dir       = r_dir;
        n_pv        = r_pv;
        n_pin       = r_pin;
        n_pdir      = r_pdir;
        n_exposed   = r_exposed;
        n_own_addr  = r_own_addr;
        n_own_marks = r_own_marks;
        n_idx       = r_idx;
        n_vis_count = r_vis_count;
        n_clr_addr  = r_clr_addr;
        n_out_idx   = r_out_idx;
        n_out_dir   = r_out_dir;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_last  = r_out_last;
        // The output register empties when its transaction completes.
        n_out_valid = r_out_valid && i_out_stall;

        mem_ctl     = '0;
        mem_addr    = nbr_addr;

        // Judge the neighbour read issued in the previous cycle: classify
        // looks at the occupied bit, emit at the visible bit. A neighbour
        // outside the grid always counts as exposed.
        mark_bit = (r_op == OP_CLASSIFY) ? mem_rd_data[MARK_OCC] : mem_rd_data[MARK_VIS];
        hit      = r_pv && (!r_pin || !mark_bit);

        // Lowest exposed face goes out first.
        sel_dir = DIR_PX;
        for (int i = FACE_COUNT - 1; i >= 0; i--) begin
            if (r_exposed[i]) begin
                sel_dir = DIR_W'(i);
            end
        end
        rest = r_exposed & ~(FACE_COUNT'(1) << sel_dir);

        case (r_state)
            S_CLEAR: begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_data = '0;
                mem_addr        = r_clr_addr;
                n_clr_addr      = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    n_op  = t_op'(i_operation);
                    n_x   = i_x_pos;
                    n_y   = i_y_pos;
                    n_z   = i_z_pos;
                    n_dir = DIR_SELF;
                    if (t_op'(i_operation) == OP_CLEAR) begin
                        n_clr_addr  = '0;
                        n_vis_count = '0;
                        n_state     = S_CLEAR;
                    end else begin
                        n_state = S_SELF;
                    end
                end
            end

            S_SELF: begin
                if (nbr_in_grid) begin
                    mem_ctl.rd_en = 1'b1;
                    n_own_addr    = nbr_addr;
                    n_state       = S_OWN;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_OWN: begin
                n_own_marks = mem_rd_data;
                n_dir       = DIR_PX;
                n_pv        = 1'b0;
                n_exposed   = '0;
                case (r_op)
                    OP_MARK: begin
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_data = mem_rd_data | MASK_OCC;
                        mem_addr        = r_own_addr;
                        n_state         = S_IDLE;
                    end
                    OP_CLASSIFY: begin
                        n_state = mem_rd_data[MARK_OCC] ? S_NBR : S_IDLE;
                    end
                    OP_EMIT: begin
                        if (mem_rd_data[MARK_VIS]) begin
                            n_idx       = r_vis_count[IDX_W-1:0];
                            n_vis_count = r_vis_count + CNT_W'(1);
                            n_state     = S_NBR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_NBR: begin
                n_exposed = r_exposed | (hit ? (FACE_COUNT'(1) << r_pdir) : '0);
                if (r_dir < DIR_SELF) begin
                    mem_ctl.rd_en = nbr_in_grid;
                    n_pv          = 1'b1;
                    n_pin         = nbr_in_grid;
                    n_pdir        = r_dir;
                    n_dir         = r_dir + DIR_W'(1);
                end else begin
                    // All six judged; the port is free for the visible write.
                    n_pv = 1'b0;
                    if (r_op == OP_CLASSIFY) begin
                        if (|n_exposed) begin
                            mem_ctl.wr_en   = 1'b1;
                            mem_ctl.wr_data = r_own_marks | MASK_VIS;
                            mem_addr        = r_own_addr;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_state = (|n_exposed) ? S_EMIT : S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_dir   = sel_dir;
                    n_out_x     = r_x[FACE_W-1:0];
                    n_out_y     = r_y[FACE_W-1:0];
                    n_out_z     = r_z[FACE_W-1:0];
                    n_out_last  = (rest == '0);
                    n_exposed   = rest;
                    if (rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_vis_count <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_size_x    <= SIZE_RESET;
            r_size_y    <= SIZE_RESET;
            r_size_z    <= SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_vis_count <= n_vis_count;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GRID_X: r_size_x <= i_cfg_data;
                    CFG_GRID_Y: r_size_y <= i_cfg_data;
                    CFG_GRID_Z: r_size_z <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
        r_op        <= n_op;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_dir       <= n_dir;
        r_pin       <= n_pin;
        r_pdir      <= n_pdir;
        r_exposed   <= n_exposed;
        r_own_addr  <= n_own_addr;
        r_own_marks <= n_own_marks;
        r_idx       <= n_idx;
        r_out_idx   <= n_out_idx;
        r_out_dir   <= n_out_dir;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_z     <= n_out_z;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_voxel_index = r_out_idx;
    assign o_face_dir    = r_out_dir;
    assign o_face_x      = r_out_x;
    assign o_face_y      = r_out_y;
    assign o_face_z      = r_out_z;
    assign o_last_face   = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The single-port store never sees a read and a write together.
    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("cell store read and written in the same cycle");

    // A new result only appears while the sequencer is handing out faces.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit phase");

    // A face that is not the voxel's last leaves further faces pending.
    a_last_face_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_face) |-> (r_state == S_EMIT && r_exposed != '0))
        else $error("non-final face with no faces left to send");

endmodule
